>>> rtl/core/gng_pkg.sv
// ----------------------------------------------------------------------------
// gng_pkg
// Shared types, widths and the control store for the grid neighbour generator.
// ----------------------------------------------------------------------------
package gng_pkg;

	localparam int SIZE_W     = 11;               // size registers
	localparam int NODE_W     = 30;               // node / neighbour index
	localparam int PLANE_W    = 2 * SIZE_W;       // size_y * size_z
	localparam int TOTAL_W    = 3 * SIZE_W;       // node count of the grid
	localparam int CAND_W     = NODE_W + 1;       // node + plane, no overflow
	localparam int COORD_W    = SIZE_W + 1;       // coordinate with carry room
	localparam int CNT_W      = 33;               // edge counter
	localparam int NUM_CAND   = 6;
	localparam int CAND_IDX_W = 3;
	localparam int QBITS      = SIZE_W;           // quotient bits per division
	localparam int DIV_CNT_W  = 4;
	localparam int PC_W       = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_MUL_PLANE,
		OP_MUL_TOTAL,
		OP_CHECK,
		OP_DIV,
		OP_DIVY_INIT,
		OP_SETUP,
		OP_EVAL,
		OP_EMIT,
		OP_ERR,
		OP_NONE
	} op_t;

	// sequencer jump conditions
	typedef enum logic [3:0] {
		JC_NEXT,
		JC_GOTO,
		JC_WAIT_IN,
		JC_IF_GE,
		JC_LOOP_CNT,
		JC_LOOP_M,
		JC_IF_ZERO,
		JC_EMIT,
		JC_OUT
	} jc_t;

	typedef struct packed {
		op_t             op;
		jc_t             jc;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic ge_total;
		logic cnt_zero;
		logic m_last;
		logic mask_zero;
		logic emit_done;
		logic out_free;
	} dp_status_t;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_ERR  = 4'd11;
	localparam logic [PC_W-1:0] PC_NONE = 4'd12;

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_NOP, jc: JC_GOTO, target: PC_IDLE};
		case (pc)
			4'd0:  w = '{op: OP_IDLE,      jc: JC_WAIT_IN,  target: PC_IDLE};
			4'd1:  w = '{op: OP_MUL_PLANE, jc: JC_NEXT,     target: PC_IDLE};
			4'd2:  w = '{op: OP_MUL_TOTAL, jc: JC_NEXT,     target: PC_IDLE};
			4'd3:  w = '{op: OP_CHECK,     jc: JC_IF_GE,    target: PC_ERR};
			4'd4:  w = '{op: OP_DIV,       jc: JC_LOOP_CNT, target: PC_IDLE};
			4'd5:  w = '{op: OP_DIVY_INIT, jc: JC_NEXT,     target: PC_IDLE};
			4'd6:  w = '{op: OP_DIV,       jc: JC_LOOP_CNT, target: PC_IDLE};
			4'd7:  w = '{op: OP_SETUP,     jc: JC_NEXT,     target: PC_IDLE};
			4'd8:  w = '{op: OP_EVAL,      jc: JC_LOOP_M,   target: PC_IDLE};
			4'd9:  w = '{op: OP_NOP,       jc: JC_IF_ZERO,  target: PC_NONE};
			4'd10: w = '{op: OP_EMIT,      jc: JC_EMIT,     target: PC_IDLE};
			4'd11: w = '{op: OP_ERR,       jc: JC_OUT,      target: PC_IDLE};
			4'd12: w = '{op: OP_NONE,      jc: JC_OUT,      target: PC_IDLE};
			default: w = '{op: OP_NOP,     jc: JC_GOTO,     target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/gng_useq.sv
// ----------------------------------------------------------------------------
// gng_useq
// Step counter and control store; picks the next step from datapath status.
// ----------------------------------------------------------------------------
module gng_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  gng_pkg::dp_status_t status,
	output gng_pkg::op_t        op
);
	import gng_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;
	uword_t          uw;

	assign uw     = ucode_rom(pc_q);
	assign pc_inc = pc_q + 4'd1;
	assign op     = uw.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		pc_d = pc_q;
		case (uw.jc)
			JC_NEXT:     pc_d = pc_inc;
			JC_GOTO:     pc_d = uw.target;
			JC_WAIT_IN:  pc_d = status.in_fire   ? pc_inc    : pc_q;
			JC_IF_GE:    pc_d = status.ge_total  ? uw.target : pc_inc;
			JC_LOOP_CNT: pc_d = status.cnt_zero  ? pc_inc    : pc_q;
			JC_LOOP_M:   pc_d = status.m_last    ? pc_inc    : pc_q;
			JC_IF_ZERO:  pc_d = status.mask_zero ? uw.target : pc_inc;
			JC_EMIT:     pc_d = status.emit_done ? uw.target : pc_q;
			JC_OUT:      pc_d = status.out_free  ? uw.target : pc_q;
			default:     pc_d = PC_IDLE;
		endcase
	end

endmodule

>>> rtl/core/gng_cand.sv
// ----------------------------------------------------------------------------
// gng_cand
// One stencil candidate: linear index, range check and mixed-radix position,
// kept when the squared distance to the node is at most one.
// ----------------------------------------------------------------------------
module gng_cand (
	input  logic [gng_pkg::CAND_IDX_W-1:0] m,
	input  logic [gng_pkg::NODE_W-1:0]     node,
	input  logic [gng_pkg::SIZE_W-1:0]     x,
	input  logic [gng_pkg::SIZE_W-1:0]     y,
	input  logic [gng_pkg::SIZE_W-1:0]     z,
	input  logic [gng_pkg::SIZE_W-1:0]     sy,
	input  logic [gng_pkg::SIZE_W-1:0]     sz,
	input  logic [gng_pkg::PLANE_W-1:0]    plane,
	input  logic [gng_pkg::TOTAL_W-1:0]    total,
	output logic [gng_pkg::CAND_W-1:0]     cand,
	output logic                           keep
);
	import gng_pkg::*;

	logic [1:0]         axis;
	logic               dec;
	logic [PLANE_W-1:0] d;
	logic               under;
	logic               in_range;
	logic [COORD_W-1:0] xe, ye, ze, sye, sze;
	logic [COORD_W-1:0] cx, cy, cz;
	logic [COORD_W-1:0] dx, dy, dz;
	logic               z_hit, y_hit, x_hit, z_wrap, y_wrap;
	logic               sx_ok, sy_ok, sz_ok;
	logic               nzx, nzy, nzz;

	assign axis = m[2:1];
	assign dec  = m[0];
	assign xe   = COORD_W'(x);
	assign ye   = COORD_W'(y);
	assign ze   = COORD_W'(z);
	assign sye  = COORD_W'(sy);
	assign sze  = COORD_W'(sz);

	always_comb begin
		case (axis)
			2'd0:    d = PLANE_W'(1);
			2'd1:    d = PLANE_W'(sz);
			default: d = plane;
		endcase
	end

	assign under    = dec && (CAND_W'(node) < CAND_W'(d));
	assign cand     = dec ? CAND_W'(node) - CAND_W'(d) : CAND_W'(node) + CAND_W'(d);
	assign in_range = !under && (TOTAL_W'(cand) < total);

	// position of the candidate as a carry / borrow through z, y, x digits
	always_comb begin
		z_hit = (axis == 2'd0);
		if (!dec) begin
			z_wrap = z_hit && ((ze + 1'b1) == sze);
			cz     = z_hit ? (z_wrap ? '0 : ze + 1'b1) : ze;
			y_hit  = (axis == 2'd1) || z_wrap;
			y_wrap = y_hit && ((ye + 1'b1) == sye);
			cy     = y_hit ? (y_wrap ? '0 : ye + 1'b1) : ye;
			x_hit  = (axis == 2'd2) || y_wrap;
			cx     = x_hit ? xe + 1'b1 : xe;
		end else begin
			z_wrap = z_hit && (ze == '0);
			cz     = z_hit ? (z_wrap ? sze - 1'b1 : ze - 1'b1) : ze;
			y_hit  = (axis == 2'd1) || z_wrap;
			y_wrap = y_hit && (ye == '0);
			cy     = y_hit ? (y_wrap ? sye - 1'b1 : ye - 1'b1) : ye;
			x_hit  = (axis == 2'd2) || y_wrap;
			cx     = x_hit ? xe - 1'b1 : xe;
		end
	end

	assign dx = xe - cx;
	assign dy = ye - cy;
	assign dz = ze - cz;

	assign nzx   = (dx != '0);
	assign nzy   = (dy != '0);
	assign nzz   = (dz != '0);
	assign sx_ok = !nzx || (dx == COORD_W'(1)) || (dx == '1);
	assign sy_ok = !nzy || (dy == COORD_W'(1)) || (dy == '1);
	assign sz_ok = !nzz || (dz == COORD_W'(1)) || (dz == '1);

	assign keep = in_range && sx_ok && sy_ok && sz_ok
		&& !(nzx && nzy) && !(nzx && nzz) && !(nzy && nzz);

endmodule

>>> rtl/core/gng_dp.sv
// ----------------------------------------------------------------------------
// gng_dp
// Datapath: grid size products, shift-subtract divider, candidate mask,
// edge counter and the result register.
// ----------------------------------------------------------------------------
module gng_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gng_pkg::op_t                op,
	input  logic [gng_pkg::SIZE_W-1:0]  sx,
	input  logic [gng_pkg::SIZE_W-1:0]  sy,
	input  logic [gng_pkg::SIZE_W-1:0]  sz,
	input  logic                        in_valid,
	input  logic [gng_pkg::NODE_W-1:0]  node_index,
	input  logic                        clear_count,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [gng_pkg::NODE_W-1:0]  neighbour_index,
	output logic                        neighbour_valid,
	output logic [gng_pkg::CNT_W-1:0]   edge_offset,
	output logic                        last_result,
	output logic                        index_error,
	output gng_pkg::dp_status_t         status
);
	import gng_pkg::*;

	logic [NODE_W-1:0]     node_q;
	logic [PLANE_W-1:0]    plane_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [NODE_W-1:0]     rem_q;
	logic [PLANE_W-1:0]    div_q;
	logic [QBITS-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0]     x_q, y_q, z_q;
	logic [CAND_IDX_W-1:0] m_q;
	logic [NUM_CAND-1:0]   mask_q;
	logic [CNT_W-1:0]      edge_q;
	logic                  out_valid_q;
	logic [NODE_W-1:0]     nb_q;
	logic                  nb_valid_q;
	logic [CNT_W-1:0]      offset_q;
	logic                  last_q;
	logic                  err_q;

	logic [TOTAL_W-1:0]    shifted;
	logic [TOTAL_W-1:0]    diff;
	logic                  div_ge;
	logic [CAND_W-1:0]     cand;
	logic                  keep;
	logic [NUM_CAND-1:0]   hi;
	logic                  last_kept;
	logic                  out_free;
	logic                  in_fire;
	logic                  emit_fire;
	logic                  m_last;
	logic [CNT_W-1:0]      edge_inc;

	gng_cand u_cand (
		.m     (m_q),
		.node  (node_q),
		.x     (x_q),
		.y     (y_q),
		.z     (z_q),
		.sy    (sy),
		.sz    (sz),
		.plane (plane_q),
		.total (total_q),
		.cand  (cand),
		.keep  (keep)
	);

	// one quotient bit per cycle, most significant first
	assign shifted = TOTAL_W'(div_q) << cnt_q;
	assign div_ge  = TOTAL_W'(rem_q) >= shifted;
	assign diff    = TOTAL_W'(rem_q) - shifted;

	assign out_free  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && (op == OP_IDLE);
	assign m_last    = (m_q == CAND_IDX_W'(NUM_CAND - 1));
	assign hi        = mask_q >> m_q;
	assign last_kept = (hi[NUM_CAND-1:1] == '0);
	assign emit_fire = (op == OP_EMIT) && mask_q[m_q] && out_free;
	assign edge_inc  = (edge_q == '1) ? edge_q : edge_q + 1'b1;

	assign status.in_fire   = in_fire;
	assign status.ge_total  = (TOTAL_W'(node_q) >= total_q);
	assign status.cnt_zero  = (cnt_q == '0);
	assign status.m_last    = m_last;
	assign status.mask_zero = (mask_q == '0);
	assign status.emit_done = mask_q[m_q] && out_free && last_kept;
	assign status.out_free  = out_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && clear_count)
				edge_q <= '0;
			else if (emit_fire)
				edge_q <= edge_inc;

			if (emit_fire || (((op == OP_ERR) || (op == OP_NONE)) && out_free))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_IDLE: begin
				if (in_fire)
					node_q <= node_index;
			end
			OP_MUL_PLANE: begin
				plane_q <= sy * sz;
			end
			OP_MUL_TOTAL: begin
				total_q <= sx * plane_q;
			end
			OP_CHECK: begin
				rem_q <= node_q;
				div_q <= plane_q;
				quo_q <= '0;
				cnt_q <= DIV_CNT_W'(QBITS - 1);
			end
			OP_DIV: begin
				if (div_ge)
					rem_q <= diff[NODE_W-1:0];
				quo_q <= {quo_q[QBITS-2:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			OP_DIVY_INIT: begin
				x_q   <= quo_q;
				div_q <= PLANE_W'(sz);
				quo_q <= '0;
				cnt_q <= DIV_CNT_W'(QBITS - 1);
			end
			OP_SETUP: begin
				y_q <= quo_q;
				z_q <= rem_q[SIZE_W-1:0];
				m_q <= '0;
			end
			OP_EVAL: begin
				mask_q[m_q] <= keep;
				m_q         <= m_last ? '0 : m_q + 1'b1;
			end
			OP_EMIT: begin
				if (!mask_q[m_q] || out_free)
					m_q <= m_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			nb_q       <= cand[NODE_W-1:0];
			nb_valid_q <= 1'b1;
			offset_q   <= edge_inc;
			last_q     <= last_kept;
			err_q      <= 1'b0;
		end else if (((op == OP_ERR) || (op == OP_NONE)) && out_free) begin
			nb_q       <= '0;
			nb_valid_q <= 1'b0;
			offset_q   <= edge_q;
			last_q     <= 1'b1;
			err_q      <= (op == OP_ERR);
		end
	end

	assign out_valid       = out_valid_q;
	assign neighbour_index = nb_q;
	assign neighbour_valid = nb_valid_q;
	assign edge_offset     = offset_q;
	assign last_result     = last_q;
	assign index_error     = err_q;

endmodule

>>> rtl/core/grid_neighbour_generator.sv
// ----------------------------------------------------------------------------
// grid_neighbour_generator
// Seven-point stencil neighbours of a node in a 3D structured grid, with a
// saturating running edge count as the CSR row offset.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | node_index, clear_count
//  out     | out_valid / out_ready| neighbour_index, neighbour_valid,
//          |                      | edge_offset, last_result, index_error
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (size_x, size_y, size_z)
//
// An in-range node passes through two multiplies, two shift-subtract divisions
// of 11 quotient bits each in the shared divider, six candidate evaluations
// and an emit pass up to the last kept one; out of range gives an error beat.
// One node at a time; in_ready is high only at the idle step of the sequencer.
// A stalled out channel holds the sequencer at its emit or single-beat step.
// Reset clears the edge counter and sets every size to 1.
// ----------------------------------------------------------------------------
module grid_neighbour_generator #(
	parameter int MAX_SIDE = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gng_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gng_pkg::SIZE_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [gng_pkg::NODE_W-1:0]           node_index,
	input  logic                                 clear_count,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [gng_pkg::NODE_W-1:0]           neighbour_index,
	output logic                                 neighbour_valid,
	output logic [gng_pkg::CNT_W-1:0]            edge_offset,
	output logic                                 last_result,
	output logic                                 index_error
);
	import gng_pkg::*;

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [SIZE_W-1:0] sx, sy, sz;
	op_t               op;
	dp_status_t        status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(1);
			size_y_q <= SIZE_W'(1);
			size_z_q <= SIZE_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sides beyond MAX_SIDE are clamped
	assign sx = (32'(size_x_q) > MAX_SIDE) ? SIZE_W'(MAX_SIDE) : size_x_q;
	assign sy = (32'(size_y_q) > MAX_SIDE) ? SIZE_W'(MAX_SIDE) : size_y_q;
	assign sz = (32'(size_z_q) > MAX_SIDE) ? SIZE_W'(MAX_SIDE) : size_z_q;

	assign in_ready = (op == OP_IDLE);

	gng_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	gng_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.sx              (sx),
		.sy              (sy),
		.sz              (sz),
		.in_valid        (in_valid),
		.node_index      (node_index),
		.clear_count     (clear_count),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.neighbour_index (neighbour_index),
		.neighbour_valid (neighbour_valid),
		.edge_offset     (edge_offset),
		.last_result     (last_result),
		.index_error     (index_error),
		.status          (status)
	);

endmodule
